// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another at the same clock edge.
`define ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// Check that a condition implies another at the next clock edge.
`define ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/life3d_pkg.sv =====
// Package: types, constants and helpers of the 3D life grid stepper.
`timescale 1ns / 1ps
package life3d_pkg;

   localparam int EXT      = 16;
   localparam int IDX_W    = $clog2(EXT);
   localparam int SIZE_W   = IDX_W + 1;
   localparam int ROW_AW   = 2 * IDX_W;
   localparam int ROWS     = EXT * EXT;
   localparam int CNT_W    = 5;
   localparam int CFG_W    = 5;
   localparam int K_W      = 4;
   localparam int NB_ROWS  = 9;
   localparam int CENTER_K = 4;
   localparam int CSR_AW   = 4;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(EXT);

   localparam logic [1:0] CSR_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] coord_height;
      logic [3:0] coord_width;
      logic [3:0] coord_length;
      logic       cell_value;
   } req_type;

   typedef struct packed {
      logic       cell_alive;
      logic [4:0] live_neighbours;
      logic       out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_GATHER,
      ST_FINISH,
      ST_WR_READ,
      ST_WR_COMMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic           load_req;
      logic           row_clear;
      logic           row_next;
      logic           rd_issue;
      logic [K_W-1:0] rd_k;
      logic           gather_start;
      logic           acc_en;
      logic           wr_clear;
      logic           wr_cell;
      logic           wr_row;
      logic           swap;
      logic           load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       in_grid;
      logic       row_last;
      logic       out_busy;
   } dp_status_type;

   // Clamp a size register to 1..EXT.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > EXT) begin
         r = SIZE_W'(EXT);
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/life_3d_grid_stepper.sv =====
// Top level of the 3D life grid stepper (B3/S23, 26-cell neighborhood, no wrap).
// Steps to a result: in-range write: decode, row read, cell commit, result load; in-range read:
// decode, nine neighbor rows one a cycle plus a drain step, finish, result load; out-of-range
// or no-op: decode, result load. Step: nine row reads per grid row through the single read port.
// One request at a time, taken in the cycle after the last result loads, even while it waits.
// Synchronous reset; after reset a clearing pass over all 256 rows stalls requests (CSR writes work).
`timescale 1ns / 1ps
module life_3d_grid_stepper (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  life3d_pkg::req_type                req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output life3d_pkg::rsp_type                rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [life3d_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import life3d_pkg::*;

   // Size registers, raw as written; clamped before use.
   logic [CFG_W-1:0]  len_ff, wid_ff, hgt_ff;
   logic [1:0]        csr_idx;
   logic              csr_wr;
   logic [SIZE_W-1:0] len_size, wid_size, hgt_size;
   ctl_cmd_type       dp_cmd;
   dp_status_type     dp_status;

   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= CFG_RESET;
         wid_ff <= CFG_RESET;
         hgt_ff <= CFG_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_LENGTH: len_ff <= csr_pwdata[CFG_W-1:0];
            CSR_WIDTH:  wid_ff <= csr_pwdata[CFG_W-1:0];
            CSR_HEIGHT: hgt_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_LENGTH: csr_prdata = 32'(len_ff);
         CSR_WIDTH:  csr_prdata = 32'(wid_ff);
         CSR_HEIGHT: csr_prdata = 32'(hgt_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Clamp: zero acts as one, anything above the grid extent acts as the extent.
   assign len_size = eff_size(len_ff);
   assign wid_size = eff_size(wid_ff);
   assign hgt_size = eff_size(hgt_ff);

   // Sequence clearing, decode, neighbor walk and row commit.
   life3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Hold the two row buffers, per-lane counters and the result register.
   life3d_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .len_size    (len_size),
      .wid_size    (wid_size),
      .hgt_size    (hgt_size),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`include "assert_macros.svh"

   // Never overwrite a result that is still waiting.
   `ASSERT_SAME(a_no_overwrite, dp_cmd.load_rsp, !(rsp_valid && rsp_stall))
   // A row commit shares its cycle with no other memory write source.
   `ASSERT_SAME(a_one_write, dp_cmd.wr_row, !dp_cmd.wr_cell && !dp_cmd.wr_clear)
   // One request in flight: stall right after an accept.
   `ASSERT_NEXT(a_one_request, req_valid && !req_stall, req_stall)

endmodule

// ===== hw/rtl/life3d_ctrl.sv =====
// Controller state machine of the 3D life grid stepper.
`timescale 1ns / 1ps
module life3d_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  life3d_pkg::dp_status_type   status,
   output life3d_pkg::ctl_cmd_type     cmd
);
   import life3d_pkg::*;

   state_type      state_ff, state_in;
   logic [K_W-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = '0;
      case (state_ff)
         ST_CLEAR: begin
            if (status.row_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.command)
               CMD_WRITE: state_in = status.in_grid ? ST_WR_READ : ST_DONE;
               CMD_READ:  state_in = status.in_grid ? ST_GATHER : ST_DONE;
               CMD_STEP:  state_in = ST_GATHER;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_GATHER: begin
            k_in = k_ff + K_W'(1);
            if (k_ff == K_W'(NB_ROWS)) begin
               state_in = ST_FINISH;
               k_in     = '0;
            end
         end
         ST_FINISH: begin
            if (status.command == CMD_STEP && !status.row_last) state_in = ST_GATHER;
            else state_in = ST_DONE;
         end
         ST_WR_READ:   state_in = ST_WR_COMMIT;
         ST_WR_COMMIT: state_in = ST_DONE;
         ST_DONE: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_clear = 1'b1;
            cmd.row_next = 1'b1;
         end
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_DECODE: begin
            cmd.row_clear = (status.command == CMD_STEP);
         end
         ST_GATHER: begin
            cmd.rd_issue     = (k_ff < K_W'(NB_ROWS));
            cmd.rd_k         = k_ff;
            cmd.gather_start = (k_ff == '0);
            cmd.acc_en       = (k_ff != '0);
         end
         ST_FINISH: begin
            if (status.command == CMD_STEP) begin
               cmd.wr_row   = 1'b1;
               cmd.row_next = !status.row_last;
               cmd.swap     = status.row_last;
            end
         end
         ST_WR_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_k     = K_W'(CENTER_K);
         end
         ST_WR_COMMIT: begin
            cmd.wr_cell = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = !status.out_busy;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/life3d_dp.sv =====
// Datapath of the 3D life grid stepper: row memories, counters, result register.
`timescale 1ns / 1ps
module life3d_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  life3d_pkg::req_type                   req_payload,
   input  logic [life3d_pkg::SIZE_W-1:0]         len_size,
   input  logic [life3d_pkg::SIZE_W-1:0]         wid_size,
   input  logic [life3d_pkg::SIZE_W-1:0]         hgt_size,
   input  life3d_pkg::ctl_cmd_type               cmd,
   output life3d_pkg::dp_status_type             status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output life3d_pkg::rsp_type                   rsp_payload
);
   import life3d_pkg::*;

   logic [EXT-1:0]    mem0 [ROWS];
   logic [EXT-1:0]    mem1 [ROWS];
   logic [EXT-1:0]    rd0_ff, rd1_ff;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic              buf_ff;
   logic [1:0]        command_ff;
   logic [IDX_W-1:0]  len_ff;
   logic              val_ff;
   logic              nbv_ff;
   logic [K_W-1:0]    kd_ff;
   logic [CNT_W-1:0]  cnt_ff [EXT];
   logic [EXT-1:0]    center_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  row_h, row_w;
   logic [SIZE_W-1:0] nh, nw;
   logic              nb_valid;
   logic [ROW_AW-1:0] raddr;
   logic [EXT-1:0]    lmask, rd_row, rm, sl, sr, new_row, cell_row;
   logic              row_in_use, in_grid, we, wbuf;
   logic [EXT-1:0]    wdata;

   assign row_h = row_ff[ROW_AW-1:IDX_W];
   assign row_w = row_ff[IDX_W-1:0];
   assign rd_row = buf_ff ? rd1_ff : rd0_ff;

   // Neighbor row address for step k of the 3x3 walk.
   always_comb begin
      nh = {1'b0, row_h};
      nw = {1'b0, row_w};
      if (cmd.rd_k inside {[0:2]}) nh = nh - SIZE_W'(1);
      if (cmd.rd_k inside {[6:8]}) nh = nh + SIZE_W'(1);
      if (cmd.rd_k inside {0, 3, 6}) nw = nw - SIZE_W'(1);
      if (cmd.rd_k inside {2, 5, 8}) nw = nw + SIZE_W'(1);
      nb_valid = (nh < hgt_size) && (nw < wid_size);
      raddr    = {nh[IDX_W-1:0], nw[IDX_W-1:0]};
   end

   always_comb begin
      for (int i = 0; i < EXT; i++) begin
         lmask[i] = (SIZE_W'(i) < len_size);
      end
   end

   assign rm = rd_row & lmask;
   assign sl = rm << 1;
   assign sr = rm >> 1;

   assign row_in_use = ({1'b0, row_h} < hgt_size) && ({1'b0, row_w} < wid_size);
   assign in_grid    = row_in_use && ({1'b0, len_ff} < len_size);

   // Apply birth on three, survival on two or three; leave cells outside the region as is.
   always_comb begin
      for (int i = 0; i < EXT; i++) begin
         if (row_in_use && lmask[i]) begin
            if (center_ff[i]) new_row[i] = (cnt_ff[i] == CNT_W'(2)) || (cnt_ff[i] == CNT_W'(3));
            else new_row[i] = (cnt_ff[i] == CNT_W'(3));
         end else begin
            new_row[i] = center_ff[i];
         end
      end
   end

   always_comb begin
      cell_row         = rd_row;
      cell_row[len_ff] = val_ff;
   end

   always_comb begin
      we    = cmd.wr_clear | cmd.wr_cell | cmd.wr_row;
      wbuf  = cmd.wr_row ? ~buf_ff : buf_ff;
      wdata = '0;
      if (cmd.wr_cell) wdata = cell_row;
      if (cmd.wr_row) wdata = new_row;
   end

   always_ff @(posedge clock) begin
      if (we && !wbuf) mem0[row_ff] <= wdata;
      if (we && wbuf) mem1[row_ff] <= wdata;
      rd0_ff <= mem0[raddr];
      rd1_ff <= mem1[raddr];
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.load_req) row_in = {req_payload.coord_height[IDX_W-1:0],
                                  req_payload.coord_width[IDX_W-1:0]};
      if (cmd.row_clear) row_in = '0;
      if (cmd.row_next) row_in = row_ff + ROW_AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         buf_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (cmd.swap) buf_ff <= ~buf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_payload.command;
         len_ff     <= req_payload.coord_length[IDX_W-1:0];
         val_ff     <= req_payload.cell_value;
      end
      if (cmd.rd_issue) begin
         nbv_ff <= nb_valid;
         kd_ff  <= cmd.rd_k;
      end
      for (int i = 0; i < EXT; i++) begin
         if (cmd.gather_start) begin
            cnt_ff[i] <= '0;
         end else if (cmd.acc_en && nbv_ff) begin
            cnt_ff[i] <= cnt_ff[i] + CNT_W'(sl[i]) + CNT_W'(sr[i])
                         + CNT_W'((kd_ff != K_W'(CENTER_K)) & rm[i]);
         end
      end
      if (cmd.acc_en && kd_ff == K_W'(CENTER_K)) center_ff <= rd_row;
   end

   // Result register; a new result loads only when the slot is free.
   always_comb begin
      rsp_in                 = '0;
      if (command_ff == CMD_READ && in_grid) begin
         rsp_in.cell_alive      = center_ff[len_ff];
         rsp_in.live_neighbours = cnt_ff[len_ff];
      end
      rsp_in.out_of_range = (command_ff == CMD_READ || command_ff == CMD_WRITE) && !in_grid;
      rsp_valid_in        = cmd.load_rsp | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (cmd.load_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.command  = command_ff;
   assign status.in_grid  = in_grid;
   assign status.row_last = &row_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

endmodule
